// ----- rtl/core/fir_decimator_assert.svh -----
// Assertion macros shared by the checking code of the decimating filter.
`ifndef FIR_DECIMATOR_ASSERT_SVH
`define FIR_DECIMATOR_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define FIRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FIRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fird_pkg.sv -----
package fird_pkg;

	// Default sizes of the stores and of the number formats.
	localparam int unsigned MAX_TAPS_DEF    = 1024;
	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned COEF_BITS_DEF   = 18;

	// Fixed field and register widths.
	localparam int unsigned ACC_W      = 48;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned RATIO_W    = 7;
	localparam int unsigned ORDER_W    = 10;
	localparam int unsigned PHASE_W    = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;

	// Register reset values and the ratio limit.
	localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(24);
	localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(744);
	localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(64);

	// Input word kinds.
	localparam logic MODE_COEF   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} fird_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic coef_wr;
		logic push;
		logic rd_en;
		logic rd_last;
		logic out_load;
	} fird_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic acc_done;
		logic out_free;
	} fird_sts_t;

endpackage

// ----- rtl/core/fird_if.sv -----
// Input channel: coefficient loads and samples.
interface fird_in_if #(
	parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_BITS   = fird_pkg::COEF_BITS_DEF
);
	import fird_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [IDX_W-1:0]              coef_index;
	logic signed [COEF_BITS-1:0]   coef_value;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source(output valid, mode, coef_index, coef_value, sample_in, input ready);
	modport sink(input valid, mode, coef_index, coef_value, sample_in, output ready);
endinterface

// Output channel: filtered samples.
interface fird_out_if #(
	parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source(output valid, sample_out, clipped, input ready);
	modport sink(input valid, sample_out, clipped, output ready);
endinterface

// ----- rtl/core/fird_ctrl.sv -----
module fird_ctrl #(
	parameter int unsigned MAX_TAPS = fird_pkg::MAX_TAPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fird_in_if.sink                           din,
	input  logic                              cfg_we,
	input  logic [fird_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fird_pkg::CFG_DATA_W-1:0]   cfg_data,
	output fird_pkg::fird_cmd_t               cmd,
	input  fird_pkg::fird_sts_t               sts
);
	import fird_pkg::*;

	localparam int unsigned TAP_LIM = MAX_TAPS - 1;

	fird_state_t          state_q, state_d;
	logic [RATIO_W-1:0]   ratio_q;
	logic [ORDER_W-1:0]   order_q;
	logic [ORDER_W-1:0]   seen_q, seen_d;
	logic [PHASE_W-1:0]   phase_q, phase_d;
	logic [ORDER_W-1:0]   tap_q, tap_d;
	logic [RATIO_W-1:0]   ratio_eff;
	logic [ORDER_W-1:0]   order_eff;
	logic [ORDER_W-1:0]   half;
	logic [RATIO_W-1:0]   phase_inc;
	logic                 accept;

	// Effective ratio and order after clamping.
	always_comb begin
		if (ratio_q == '0) begin
			ratio_eff = RATIO_W'(1);
		end else if (ratio_q > RATIO_MAX) begin
			ratio_eff = RATIO_MAX;
		end else begin
			ratio_eff = ratio_q;
		end
		if (32'(order_q) > TAP_LIM) begin
			order_eff = ORDER_W'(TAP_LIM);
		end else begin
			order_eff = order_q;
		end
		half      = order_eff >> 1;
		phase_inc = RATIO_W'(phase_q) + RATIO_W'(1);
	end

	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;

	// Next state, counters and datapath commands.
	always_comb begin
		state_d = state_q;
		seen_d  = seen_q;
		phase_d = phase_q;
		tap_d   = tap_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && din.mode == MODE_COEF) begin
					cmd.coef_wr = 1'b1;
				end else if (accept) begin
					cmd.push = 1'b1;
					tap_d    = '0;
					if (seen_q < half) begin
						seen_d = seen_q + ORDER_W'(1);
					end else begin
						if (phase_q == '0) begin
							state_d = ST_MAC;
						end
						phase_d = (phase_inc >= ratio_eff) ? '0 : phase_inc[PHASE_W-1:0];
					end
				end
			end
			ST_MAC: begin
				cmd.rd_en = 1'b1;
				tap_d     = tap_q + ORDER_W'(1);
				if (tap_q == order_eff) begin
					cmd.rd_last = 1'b1;
					state_d     = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.acc_done && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			phase_q <= '0;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			seen_q  <= seen_d;
			phase_q <= phase_d;
			tap_q   <= tap_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RST;
			order_q <= ORDER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
				CFG_ORDER: order_q <= cfg_data[ORDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/fird_dp.sv -----
module fird_dp #(
	parameter int unsigned MAX_TAPS    = fird_pkg::MAX_TAPS_DEF,
	parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_BITS   = fird_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fird_pkg::IDX_W-1:0]    coef_index,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  fird_pkg::fird_cmd_t           cmd,
	output fird_pkg::fird_sts_t           sts,
	fird_out_if.source                    dout
);
	import fird_pkg::*;

	localparam int unsigned AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int unsigned FILL_W = $clog2(MAX_TAPS + 1);
	localparam int unsigned PW     = SAMPLE_BITS + COEF_BITS;
	localparam logic [AW-1:0]     LAST_ADDR = AW'(MAX_TAPS - 1);
	localparam logic [FILL_W-1:0] FULL      = FILL_W'(MAX_TAPS);
	localparam logic signed [ACC_W:0] RND    = (ACC_W + 1)'(1) << (COEF_BITS - 2);
	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

	logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] delay_mem [MAX_TAPS];

	logic [AW-1:0]                 ptr_q;
	logic [FILL_W-1:0]             fill_q;
	logic [AW-1:0]                 caddr_q;
	logic [AW-1:0]                 daddr_q;

	logic signed [COEF_BITS-1:0]   coef_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic                          okay_s1;
	logic                          vld_s1;
	logic                          last_s1;
	logic signed [SAMPLE_BITS-1:0] smp_z;
	logic signed [PW-1:0]          prod_s2;
	logic                          vld_s2;
	logic                          last_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          acc_done_q;

	logic signed [ACC_W:0]         rsum;
	logic signed [ACC_W:0]         rshift;
	logic                          clip_hi;
	logic                          clip_lo;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          clipped_q;

	// Coefficient store: loads beyond the store are dropped.
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && 32'(coef_index) < MAX_TAPS) begin
			coef_mem[AW'(coef_index)] <= coef_value;
		end
		coef_s1 <= coef_mem[caddr_q];
	end

	// Delay line: one write port at the write pointer, one read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			delay_mem[ptr_q] <= sample_in;
		end
		smp_s1 <= delay_mem[daddr_q];
	end

	// Write pointer and fill count; entries at or above the count read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			ptr_q <= (ptr_q == LAST_ADDR) ? '0 : ptr_q + AW'(1);
			if (fill_q != FULL) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Read addresses: taps count up, the delay line walks back from the newest sample.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			caddr_q <= '0;
			daddr_q <= ptr_q;
		end else if (cmd.rd_en) begin
			caddr_q <= caddr_q + AW'(1);
			daddr_q <= (daddr_q == '0) ? LAST_ADDR : daddr_q - AW'(1);
		end
	end

	// Pipeline control alongside the registered memory reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			vld_s2     <= 1'b0;
			last_s2    <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			vld_s1  <= cmd.rd_en;
			last_s1 <= cmd.rd_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			if (cmd.push) begin
				acc_done_q <= 1'b0;
			end else if (last_s2) begin
				acc_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		okay_s1 <= FILL_W'(daddr_q) < fill_q;
	end

	// Multiply stage.
	always_comb begin
		smp_z = okay_s1 ? smp_s1 : '0;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef_s1 * smp_z;
	end

	// Accumulate stage; the sum wraps at the accumulator width.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, drop the coefficient fraction and saturate.
	always_comb begin
		rsum    = {acc_q[ACC_W-1], acc_q} + RND;
		rshift  = rsum >>> (COEF_BITS - 1);
		clip_hi = rshift > SAT_HI;
		clip_lo = rshift < SAT_LO;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (clip_hi) begin
				out_q <= SAT_HI[SAMPLE_BITS-1:0];
			end else if (clip_lo) begin
				out_q <= SAT_LO[SAMPLE_BITS-1:0];
			end else begin
				out_q <= rshift[SAMPLE_BITS-1:0];
			end
			clipped_q <= clip_hi || clip_lo;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_q;
	assign dout.clipped    = clipped_q;

	assign sts.acc_done = acc_done_q;
	assign sts.out_free = !out_valid_q || dout.ready;

endmodule

// ----- rtl/core/fir_decimator.sv -----
// Channel   Direction  Words
// din       in         coefficient loads (mode 0) and samples (mode 1)
// dout      out        filtered, decimated samples with a clip flag
// cfg       in         register writes: ratio, order
//
// A coefficient load or a sample that yields no output leaves the input ready.
// A sample that yields an output runs one multiply-accumulate per tap through
// the single MAC unit, plus memory read, multiply and round stages.
// Reset is immediate; the delay line reads as zero through a fill count.
// A waiting output word holds the next filter pass at its end, and the input
// stays stalled until that word is taken.
module fir_decimator #(
	parameter int unsigned MAX_TAPS    = fird_pkg::MAX_TAPS_DEF,
	parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_BITS   = fird_pkg::COEF_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fird_in_if.sink                         din,
	fird_out_if.source                      dout,
	input  logic                            cfg_we,
	input  logic [fird_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fird_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fird_pkg::*;

	fird_cmd_t cmd;
	fird_sts_t sts;

	fird_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	fird_dp #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_index (din.coef_index),
		.coef_value (din.coef_value),
		.sample_in  (din.sample_in),
		.cmd        (cmd),
		.sts        (sts),
		.dout       (dout)
	);

endmodule

// ----- rtl/core/fird_checker.sv -----
`include "fir_decimator_assert.svh"

module fird_checker #(
	parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_mode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_sample,
	input logic                          out_clipped
);
	import fird_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A stalled output word stays put.
	`FIRD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_clipped), "output word changed while stalled")

	// A coefficient load never makes the block busy.
	`FIRD_ASSERT_NEXT(a_coef_no_busy, clk, arst_n, in_acc && in_mode == MODE_COEF, in_ready, "coefficient load stalled the input")

	// No output word appears in the cycle right after an input word is taken.
	`FIRD_ASSERT_NEXT(a_no_instant_out, clk, arst_n, in_acc && !out_valid, !out_valid, "output appeared without a filter pass")

	// A new output word comes only at the end of a filter pass, with the input held off.
	`FIRD_ASSERT_SAME(a_out_after_pass, clk, arst_n, $rose(out_valid), $past(!in_ready), "output appeared while input was open")

endmodule

bind fir_decimator fird_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_fird_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (din.valid),
	.in_ready    (din.ready),
	.in_mode     (din.mode),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.out_sample  (dout.sample_out),
	.out_clipped (dout.clipped)
);

// ----- dv/fird_tb_pkg.sv -----
package fird_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import fird_pkg::*;

	// One filtered output word as it should leave the block.
	typedef struct {
		logic signed [SAMPLE_BITS_DEF-1:0] sample;
		logic                              clip;
	} filt_word_t;

	// Tracks the filter state, predicts each output word and checks what arrives.
	class fir_ledger;
		logic [RATIO_W-1:0]                ratio_reg;
		logic [ORDER_W-1:0]                order_reg;
		logic signed [COEF_BITS_DEF-1:0]   taps [MAX_TAPS_DEF];
		logic signed [SAMPLE_BITS_DEF-1:0] hist [MAX_TAPS_DEF];
		logic [IDX_W-1:0]                  head;
		int unsigned                       warm;
		int unsigned                       phase;
		filt_word_t                        owed_q [$];
		int unsigned                       failures;
		int unsigned                       checked;
		int unsigned                       clips;

		function new();
			ratio_reg = RATIO_RST;
			order_reg = ORDER_RST;
			foreach (taps[i]) begin
				taps[i] = '0;
				hist[i] = '0;
			end
			head     = '0;
			warm     = 0;
			phase    = 0;
			failures = 0;
			checked  = 0;
			clips    = 0;
		endfunction

		function int unsigned owed();
			return owed_q.size();
		endfunction

		// Registers outside the list are dropped, as the block does.
		function void write_reg(logic [CFG_IDX_W-1:0] ix, logic [CFG_DATA_W-1:0] v);
			if (ix == CFG_RATIO) begin
				ratio_reg = v[RATIO_W-1:0];
			end else if (ix == CFG_ORDER) begin
				order_reg = v[ORDER_W-1:0];
			end
		endfunction

		// An accepted input word: a tap load, or a sample that may finish an output.
		function void note_word(logic md, logic [IDX_W-1:0] ix,
				logic signed [COEF_BITS_DEF-1:0] cv, logic signed [SAMPLE_BITS_DEF-1:0] smp);
			int unsigned                   r;
			int unsigned                   ord;
			int unsigned                   half;
			bit                            emit;
			bit                            clip;
			logic signed [ACC_W-1:0]       acc;
			logic [IDX_W-1:0]              tap_at;
			longint                        wide;
			filt_word_t                    want;

			if (md == MODE_COEF) begin
				taps[ix] = cv;
				return;
			end
			r = ratio_reg;
			if (r == 0) begin
				r = 1;
			end
			if (r > RATIO_MAX) begin
				r = RATIO_MAX;
			end
			ord  = order_reg;
			half = ord / 2;
			hist[head] = smp;

			// Output k falls on sample k*ratio + order/2; until then only count.
			emit = 1'b0;
			if (warm < half) begin
				warm++;
			end else begin
				emit  = (phase == 0);
				phase = (phase + 1 >= r) ? 0 : phase + 1;
			end

			acc = '0;
			if (emit) begin
				for (int unsigned m = 0; m <= ord; m++) begin
					tap_at = head - IDX_W'(m);
					acc = acc + taps[m] * hist[tap_at];
				end
			end
			head = head + 1'b1;
			if (!emit) begin
				return;
			end

			// Round half up into Q1.15, then saturate.
			wide = acc;
			wide = wide + (longint'(1) << (COEF_BITS_DEF - 2));
			wide = wide >>> (COEF_BITS_DEF - 1);
			clip = 1'b0;
			if (wide > 32767) begin
				wide = 32767;
				clip = 1'b1;
			end
			if (wide < -32768) begin
				wide = -32768;
				clip = 1'b1;
			end
			if (clip) begin
				clips++;
			end
			want.sample = wide[SAMPLE_BITS_DEF-1:0];
			want.clip   = clip;
			owed_q.push_back(want);
		endfunction

		function void flag(string s);
			failures++;
			if (failures <= 10) begin
				$display("MISMATCH: %s", s);
			end
		endfunction

		// An accepted output word is held against the oldest prediction.
		function void check_output(logic signed [SAMPLE_BITS_DEF-1:0] got, logic got_clip);
			filt_word_t want;

			checked++;
			if (owed_q.size() == 0) begin
				flag($sformatf("unexpected output word %0d clip %0b", got, got_clip));
				return;
			end
			want = owed_q.pop_front();
			if (got !== want.sample || got_clip !== want.clip) begin
				flag($sformatf("output %0d: expected %0d clip %0b, got %0d clip %0b",
					checked, want.sample, want.clip, got, got_clip));
			end
		endfunction
	endclass

endpackage

// ----- dv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fird_pkg::*;
	import fird_tb_pkg::*;

	// Register indexes past the end of the list; writes to them must do nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fird_in_if  din ();
	fird_out_if dout ();

	fir_decimator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.dout      (dout),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fir_ledger   ledger = new();
	bit          tap_loaded [MAX_TAPS_DEF];
	bit          quiet;
	int unsigned hold_req;
	int unsigned cur_order;
	int unsigned samples_sent;
	int unsigned taps_sent;
	int unsigned settings_run;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A run that hangs is a failure.
	initial begin
		#100_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic signed [COEF_BITS_DEF-1:0] coef_draw(int unsigned w);
		logic signed [COEF_BITS_DEF-1:0] v;

		v = COEF_BITS_DEF'($urandom);
		return v >>> (COEF_BITS_DEF - w);
	endfunction

	// Mostly scaled noise, now and then a full-scale value.
	function automatic logic signed [SAMPLE_BITS_DEF-1:0] sample_draw(int unsigned w);
		logic signed [SAMPLE_BITS_DEF-1:0] v;

		if ($urandom_range(0, 15) == 0) begin
			return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		end
		v = SAMPLE_BITS_DEF'($urandom);
		return v >>> (SAMPLE_BITS_DEF - w);
	endfunction

	// All driver tasks start and end at a falling edge.
	task automatic set_reg(logic [CFG_IDX_W-1:0] ix, int unsigned v);
		cfg_we    <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= CFG_DATA_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger.write_reg(ix, CFG_DATA_W'(v));
		if (ix == CFG_ORDER) begin
			cur_order = v % MAX_TAPS_DEF;
		end
		@(negedge clk);
	endtask

	// Offer one input word after a random gap and wait for it to be taken.
	task automatic put_word(logic md, logic [IDX_W-1:0] ix,
			logic signed [COEF_BITS_DEF-1:0] cv, logic signed [SAMPLE_BITS_DEF-1:0] smp);
		while (!quiet && $urandom_range(0, 99) < 21) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid      <= 1'b1;
		din.mode       <= md;
		din.coef_index <= ix;
		din.coef_value <= cv;
		din.sample_in  <= smp;
		do @(posedge clk); while (!din.ready);
		ledger.note_word(md, ix, cv, smp);
		if (md == MODE_COEF) begin
			tap_loaded[ix] = 1'b1;
			taps_sent++;
		end else begin
			samples_sent++;
		end
		@(negedge clk);
	endtask

	task automatic drain_out();
		din.valid <= 1'b0;
		while (ledger.owed() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Let the last silent samples finish before touching registers.
	task automatic settle();
		drain_out();
		repeat (cur_order + 16) @(posedge clk);
		@(negedge clk);
	endtask

	// One setting of ratio and order with a stream of samples and stray tap loads.
	task automatic run_phase(int unsigned rv, int unsigned ov, int unsigned n,
			bit hold, bit mid_pause);
		int unsigned cw;
		int unsigned sw;

		cw = $urandom_range(6, COEF_BITS_DEF);
		sw = $urandom_range(4, SAMPLE_BITS_DEF);
		set_reg(CFG_RATIO, rv);
		set_reg(CFG_ORDER, ov);
		settings_run++;

		// Every tap that the sum reads must hold a value; short filters get fresh ones.
		for (int unsigned t = 0; t <= ov % MAX_TAPS_DEF; t++) begin
			if (!tap_loaded[t] || ov <= 64) begin
				put_word(MODE_COEF, IDX_W'(t), coef_draw(cw), 16'($urandom));
			end
		end
		if (hold) begin
			hold_req = 400;
		end
		for (int unsigned i = 0; i < n; i++) begin
			if (mid_pause && i == n / 2) begin
				drain_out();
			end
			if ($urandom_range(0, 9) == 0) begin
				put_word(MODE_COEF, IDX_W'($urandom_range(0, MAX_TAPS_DEF - 1)),
					coef_draw(cw), 16'($urandom));
			end else begin
				put_word(MODE_SAMPLE, IDX_W'($urandom), 18'($urandom), sample_draw(sw));
			end
		end
		settle();
	endtask

	// Output side: random back-pressure, long holds on request, check each word.
	initial begin
		int unsigned hold_left;

		hold_left  = 0;
		dout.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				dout.ready <= 1'b0;
				hold_left--;
			end else begin
				dout.ready <= quiet || $urandom_range(0, 99) >= 21;
			end
			@(posedge clk);
			if (dout.valid && dout.ready) begin
				ledger.check_output(dout.sample_out, dout.clipped);
			end
		end
	end

	// Input side and register writes.
	initial begin
		int unsigned                       phase_no;
		int unsigned                       rv;
		int unsigned                       ov;
		logic signed [SAMPLE_BITS_DEF-1:0] kick [14];

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		din.valid      = 1'b0;
		din.mode       = MODE_COEF;
		din.coef_index = '0;
		din.coef_value = '0;
		din.sample_in  = '0;
		quiet          = 1'b0;
		hold_req       = 0;
		cur_order      = ORDER_RST;
		samples_sent   = 0;
		taps_sent      = 0;
		settings_run   = 0;
		foreach (tap_loaded[i]) begin
			tap_loaded[i] = 1'b0;
		end
		kick = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Writes past the register list must leave ratio and order alone.
		set_reg(CFG_SPARE_LO, 1023);
		set_reg(CFG_SPARE_HI, 5);

		// Short filter at full rate, extreme taps and samples to clip both ways.
		set_reg(CFG_RATIO, 1);
		set_reg(CFG_ORDER, 4);
		put_word(MODE_COEF, IDX_W'(0), 18'sh1ffff, 16'sh0000);
		put_word(MODE_COEF, IDX_W'(1), 18'sh1ffff, 16'shffff);
		put_word(MODE_COEF, IDX_W'(2), 18'sh20000, 16'sh0000);
		put_word(MODE_COEF, IDX_W'(3), 18'sh1ffff, 16'shffff);
		put_word(MODE_COEF, IDX_W'(4), 18'sh00001, 16'sh0000);
		foreach (kick[i]) begin
			if (i == 7) begin
				put_word(MODE_COEF, IDX_W'(2), 18'sh00000, 16'sh7fff);
			end
			put_word(MODE_SAMPLE, IDX_W'(1023), 18'sh3ffff, kick[i]);
		end
		settle();

		// Ratio zero, ratio past the limit with an odd order, the longest filter,
		// a single tap, and a long output stall at full rate.
		run_phase(0, 6, 40, 1'b0, 1'b0);
		run_phase(127, 9, 150, 1'b0, 1'b1);
		run_phase(64, 1023, 600, 1'b0, 1'b0);
		run_phase(1, 0, 60, 1'b0, 1'b0);
		run_phase(1, 8, 120, 1'b1, 1'b1);

		// Random settings until enough input words have gone through.
		phase_no = 0;
		while (samples_sent + taps_sent < 2400) begin
			quiet = (phase_no < 3);
			case ($urandom_range(0, 19))
				0: ov = $urandom_range(600, 1022);
				1, 2, 3: ov = $urandom_range(49, 300);
				default: ov = $urandom_range(0, 48);
			endcase
			if (ov > 300) begin
				rv = $urandom_range(32, 64);
			end else if ($urandom_range(0, 9) == 0) begin
				rv = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
			end else begin
				rv = $urandom_range(1, 64);
			end
			run_phase(rv, ov, $urandom_range(20, 80), 1'b0, $urandom_range(0, 7) == 0);
			phase_no++;
		end
		quiet = 1'b0;
		settle();

		$display("Sent %0d samples and %0d tap loads over %0d ratio/order settings.",
			samples_sent, taps_sent, settings_run);
		$display("Checked %0d filtered words, %0d of them saturated, %0d mismatches.",
			ledger.checked, ledger.clips, ledger.failures);
		if (ledger.failures == 0 && ledger.owed() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
